// ===== rtl/core/fcl_pkg.sv =====
package fcl_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int HASH_W  = 64;
    localparam int SIDE_W  = 10;
    localparam int SLOT_W  = 6;
    localparam int TAG_W   = HASH_W + SIDE_W;

    typedef enum logic [1:0] {
        STATUS_HIT     = 2'd0,
        STATUS_FILL    = 2'd1,
        STATUS_REPLACE = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [HASH_W-1:0] key_hash;
        logic [SIDE_W-1:0]        side_pixels;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } out_t;

endpackage

// ===== rtl/core/fcl_tag_ram.sv =====
module fcl_tag_ram #(
    parameter int WIDTH  = 74,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fifo_tag_cache_lookup_top.sv =====
// Fully associative tag store with first-in first-out replacement.
// The input channel (in_valid, in_ready, in_data) takes one request per transfer: a 64-bit
// hash and a pixel size. The output channel (out_valid, out_ready, out_data) gives one
// result per request: hit, miss placed in a free slot, or miss that replaced the oldest
// entry, with the physical slot that holds the key.
// The tags sit in a single-port-read memory with a registered read, and the
// controller compares one stored tag per cycle, from slot 0 up to the fill count.
// A request goes from idle through the scan state (skipped when the store is empty)
// to a done state that loads the result into the output register. in_ready rises in the
// same cycle as out_valid, so no new request is taken while a lookup is in progress.
// The result sits in an output register; the controller holds a finished result, and
// takes no new request, while the receiver stalls and the register is still occupied.
// Reset empties the store (fill count and replacement pointer go to zero) and clears
// out_valid; the tag memory itself is not cleared, since only filled slots are compared.
module fifo_tag_cache_lookup_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fcl_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fcl_pkg::out_t out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                          state_reg;
    fcl_pkg::in_t                    key_reg;
    logic [fcl_pkg::CNT_W-1:0]       fill_reg;
    logic [fcl_pkg::IDX_W-1:0]       oldest_reg;
    logic [fcl_pkg::IDX_W-1:0]       cmp_idx_reg;
    logic                            hit_reg;
    logic [fcl_pkg::IDX_W-1:0]       hit_idx_reg;
    logic                            out_valid_reg;
    fcl_pkg::out_t                   out_data_reg;

    logic [fcl_pkg::IDX_W-1:0]       rd_addr;
    logic [fcl_pkg::TAG_W-1:0]       rd_data;
    logic                            wr_en;
    logic [fcl_pkg::IDX_W-1:0]       wr_addr;
    logic                            match;
    logic                            last;
    logic                            full;
    logic                            out_free;
    logic [fcl_pkg::IDX_W-1:0]       target;
    fcl_pkg::status_t                miss_status;

    assign full     = (fill_reg == fcl_pkg::CNT_W'(fcl_pkg::ENTRIES));
    assign match    = (rd_data == {key_reg.key_hash, key_reg.side_pixels});
    assign last     = ((fcl_pkg::CNT_W'(cmp_idx_reg) + fcl_pkg::CNT_W'(1)) == fill_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign target      = full ? oldest_reg : fill_reg[fcl_pkg::IDX_W-1:0];
    assign miss_status = full ? fcl_pkg::STATUS_REPLACE : fcl_pkg::STATUS_FILL;

    assign rd_addr = (state_reg == S_SCAN) ? cmp_idx_reg + fcl_pkg::IDX_W'(1)
                                           : '0;
    assign wr_en   = (state_reg == S_DONE) && out_free && !hit_reg;
    assign wr_addr = target;

    fcl_tag_ram #(
        .WIDTH (fcl_pkg::TAG_W),
        .DEPTH (fcl_pkg::ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({key_reg.key_hash, key_reg.side_pixels}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg     <= in_data;
                        cmp_idx_reg <= '0;
                        hit_reg     <= 1'b0;
                        state_reg   <= (fill_reg == '0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                        state_reg   <= S_DONE;
                    end
                    else if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cmp_idx_reg <= cmp_idx_reg + fcl_pkg::IDX_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (hit_reg)
                        begin
                            out_data_reg.status <= fcl_pkg::STATUS_HIT;
                            out_data_reg.slot   <= fcl_pkg::SLOT_W'(hit_idx_reg);
                        end
                        else
                        begin
                            out_data_reg.status <= miss_status;
                            out_data_reg.slot   <= fcl_pkg::SLOT_W'(target);
                            if (full)
                            begin
                                oldest_reg <= (oldest_reg ==
                                               fcl_pkg::IDX_W'(fcl_pkg::ENTRIES - 1))
                                              ? '0 : oldest_reg + fcl_pkg::IDX_W'(1);
                            end
                            else
                            begin
                                fill_reg <= fill_reg + fcl_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fcl_pkg::CNT_W'(fcl_pkg::ENTRIES))
        else $error("Fill count exceeds the store depth.");

    a_oldest_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> oldest_reg == '0)
        else $error("Replacement pointer moved before the store was full.");

    a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == fcl_pkg::STATUS_REPLACE |-> full)
        else $error("Replacement reported while the store had free slots.");

    a_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> fcl_pkg::CNT_W'(out_data_reg.slot) < fill_reg)
        else $error("Result slot lies beyond the filled part of the store.");
`endif

endmodule

// ===== dv/tb_fifo_tag_cache_lookup_top.sv =====
`timescale 1ns / 1ps

module tb_fifo_tag_cache_lookup_top;

    import fcl_pkg::*;

    localparam int RANDOM_LOOKUPS = 650;
    localparam int POOL_SIZE      = 96;
    localparam int POOL_IDX_W     = $clog2(POOL_SIZE);
    localparam int IDLE_PERCENT   = 30;
    localparam int CALM_FIRST     = 250;
    localparam int CALM_LAST      = 400;
    localparam int DRAIN_CYCLES   = ENTRIES + 8;
    localparam int RUN_LIMIT      = 400000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        in_t req;
        bit  hold;
    } lookup_job_t;

    logic  clk;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    in_t   in_data = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    out_t  out_data;

    lookup_job_t pending_lookups[$];
    out_t        expected_lookups[$];

    logic [HASH_W-1:0] model_hash[ENTRIES];
    logic [SIDE_W-1:0] model_side[ENTRIES];
    int                model_fill;
    int                model_oldest;

    in_t key_pool[POOL_SIZE];

    int sent_count;
    int got_count;
    int error_count;
    int cycle_count;

    fifo_tag_cache_lookup_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    function automatic out_t predict_lookup(in_t req);
        out_t res;
        bit   found;
        found = 1'b0;
        res = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && i < model_fill && model_hash[i] == req.key_hash
                && model_side[i] == req.side_pixels)
            begin
                found = 1'b1;
                res.status = STATUS_HIT;
                res.slot = SLOT_W'(i);
            end
        end
        if (!found)
        begin
            if (model_fill < ENTRIES)
            begin
                res.status = STATUS_FILL;
                res.slot = SLOT_W'(model_fill);
                model_fill++;
            end
            else
            begin
                res.status = STATUS_REPLACE;
                res.slot = SLOT_W'(model_oldest);
                model_oldest = (model_oldest + 1 >= ENTRIES) ? 0 : model_oldest + 1;
            end
            model_hash[res.slot] = req.key_hash;
            model_side[res.slot] = req.side_pixels;
        end
        return res;
    endfunction

    function automatic in_t fresh_key();
        in_t k;
        k.key_hash = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            k.side_pixels = SIDE_W'($urandom);
        else
            k.side_pixels = SIDE_W'($urandom_range(1, 512));
        return k;
    endfunction

    function automatic logic [POOL_IDX_W-1:0] pool_index();
        return POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1));
    endfunction

    task automatic queue_request(logic [HASH_W-1:0] h, logic [SIDE_W-1:0] s, bit hold);
        lookup_job_t job;
        job.req.key_hash = h;
        job.req.side_pixels = s;
        job.hold = hold;
        pending_lookups.push_back(job);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: a new request is presented only once the previous one has been transferred.
    always @(posedge clk or negedge rst_n)
    begin
        bit launch;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_lookups.push_back(predict_lookup(in_data));
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                launch = pending_lookups.size() != 0;
                if (launch && pending_lookups[0].hold && expected_lookups.size() != 0)
                    launch = 1'b0;
                if (launch && !(sent_count >= CALM_FIRST && sent_count < CALM_LAST)
                    && $urandom_range(0, 99) < IDLE_PERCENT)
                    launch = 1'b0;
                if (launch)
                begin
                    in_data <= pending_lookups[0].req;
                    pending_lookups.pop_front();
                end
                in_valid <= launch;
            end
        end
    end

    // Monitor: every result transfer is checked against the oldest predicted lookup.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_count++;
                if (expected_lookups.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected result: status %0d slot %0d",
                                 out_data.status, out_data.slot);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (out_data.status !== want.status || out_data.slot !== want.slot)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"Result %0d mismatch: expected status %0d slot %0d,",
                                      " got status %0d slot %0d"},
                                     got_count, want.status, want.slot,
                                     out_data.status, out_data.slot);
                    end
                end
            end
            out_ready <= (got_count >= CALM_FIRST && got_count < CALM_LAST)
                         || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    initial
    begin
        in_t req;
        logic [TAG_W-1:0] flat;
        int pick;

        model_fill = 0;
        model_oldest = 0;

        queue_request(64'h8000_0000_0000_0000, 10'd1, 1'b0);
        queue_request(64'h7FFF_FFFF_FFFF_FFFF, 10'd512, 1'b0);
        queue_request(64'h0, 10'd0, 1'b0);
        queue_request(64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 10'd1, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 10'd2, 1'b0);
        queue_request(64'h8000_0000_0000_0001, 10'd1, 1'b0);
        queue_request(64'h0, 10'd0, 1'b0);
        queue_request(64'h0, 10'd1, 1'b0);
        queue_request(64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b0);
        queue_request(64'h7FFF_FFFF_FFFF_FFFF, 10'd512, 1'b0);
        queue_request(64'h7FFF_FFFF_FFFF_FFFF, 10'd513, 1'b0);
        queue_request(64'h5555_5555_5555_5555, 10'h2AA, 1'b0);
        queue_request(64'hAAAA_AAAA_AAAA_AAAA, 10'h155, 1'b0);
        queue_request(64'h5555_5555_5555_5555, 10'h2AA, 1'b0);
        queue_request(64'hAAAA_AAAA_AAAA_AAAA, 10'h155, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 10'd1, 1'b1);

        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = fresh_key();

        // A pool larger than the store gives hits, fills and replacements of live keys.
        for (int n = 0; n < RANDOM_LOOKUPS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                req = key_pool[pool_index()];
            end
            else if (pick < 85)
            begin
                req = fresh_key();
            end
            else
            begin
                flat = key_pool[pool_index()];
                flat ^= TAG_W'(1) << $urandom_range(0, TAG_W - 1);
                req = flat;
            end
            if ($urandom_range(0, 99) < 5)
                key_pool[pool_index()] = fresh_key();
            queue_request(req.key_hash, req.side_pixels,
                          n == 0 || $urandom_range(0, 99) < 2);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_lookups.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_lookups.size() != 0)
        begin
            error_count++;
            $display("%0d lookups never answered", expected_lookups.size());
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fcl_pkg.sv
rtl/core/fcl_tag_ram.sv
rtl/core/fifo_tag_cache_lookup_top.sv
dv/tb_fifo_tag_cache_lookup_top.sv
